@@ src/hlsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hlsc_pkg
// Shared types and constants of the held-lock site census.
// ----------------------------------------------------------------------------
`default_nettype none

package hlsc_pkg;

	localparam int unsigned SITE_SLOTS_DEF = 16;
	localparam int unsigned DEPTH_W        = 8;
	localparam int unsigned ADDR_W         = 32;
	localparam int unsigned CNT_W          = 32;
	localparam int unsigned DEEP_W         = 7;
	localparam int unsigned SLOT_W         = 4;

	typedef enum logic [1:0] {
		OUT_NONE = 2'd0,
		OUT_NEW  = 2'd1,
		OUT_HIT  = 2'd2,
		OUT_FULL = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;   // latch request, bump the scalar counters
		logic issue;  // read the next table slot
		logic fill;   // claim the slot under check
		logic bump;   // raise the count of the slot under check
		logic lose;   // no slot took the request
		logic load;   // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic held_in;     // incoming request holds a lock
		logic issue_done;  // every slot has been read
		logic entry_ready; // read data of the slot under check is present
		logic entry_free;
		logic entry_match;
		logic entry_last;
		logic out_free;    // output register can take a result
	} sts_t;

endpackage

`default_nettype wire

@@ src/hlsc_if.sv @@
// ----------------------------------------------------------------------------
// hlsc_in_if / hlsc_out_if
// Valid/ready channels carrying samples in and census results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hlsc_in_if;
	logic               valid;
	logic               ready;
	logic signed [7:0]  lock_depth;
	logic        [31:0] held_address;
	logic               in_tick;
	logic               in_quantum_lock;

	modport source (output valid, lock_depth, held_address, in_tick, in_quantum_lock,
		input ready);
	modport sink (input valid, lock_depth, held_address, in_tick, in_quantum_lock,
		output ready);
endinterface

interface hlsc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_total;
	logic [31:0] unsafe_total;
	logic [31:0] tick_total;
	logic [31:0] quantum_lock_total;
	logic [6:0]  deepest;
	logic [31:0] lost_total;
	logic [1:0]  outcome;
	logic [3:0]  site_slot;
	logic [31:0] site_hits;

	modport source (output valid, sample_total, unsafe_total, tick_total,
		quantum_lock_total, deepest, lost_total, outcome, site_slot, site_hits,
		input ready);
	modport sink (input valid, sample_total, unsafe_total, tick_total,
		quantum_lock_total, deepest, lost_total, outcome, site_slot, site_hits,
		output ready);
endinterface

`default_nettype wire

@@ src/hlsc_ram.sv @@
// ----------------------------------------------------------------------------
// hlsc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/hlsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hlsc_ctrl
// Sequencer: accept a request, walk the site table, hand over the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsc_ctrl
	import hlsc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = sts.held_in ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.issue = !sts.issue_done;
				if (sts.entry_ready) begin
					if (sts.entry_free) begin
						cmd.fill = 1'b1;
						state_d  = ST_FINISH;
					end else if (sts.entry_match) begin
						cmd.bump = 1'b1;
						state_d  = ST_FINISH;
					end else if (sts.entry_last) begin
						cmd.lose = 1'b1;
						state_d  = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/hlsc_dp.sv @@
// ----------------------------------------------------------------------------
// hlsc_dp
// Counters, site table with scan pointers, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsc_dp
	import hlsc_pkg::*;
#(
	parameter int unsigned SITE_SLOTS = SITE_SLOTS_DEF,
	localparam int unsigned IDX_W     = (SITE_SLOTS > 1) ? $clog2(SITE_SLOTS) : 1
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   cmd,
	output sts_t        sts,
	hlsc_in_if.sink     samples,
	hlsc_out_if.source  results
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SITE_SLOTS - 1);

	// request latch
	logic [ADDR_W-1:0] addr_q;

	// scalar counters
	logic [CNT_W-1:0]  sample_q, tick_q, qlock_q, unsafe_q, lost_q;
	logic [DEEP_W-1:0] deep_q;

	// scan pointers
	logic [IDX_W-1:0]  rd_idx_q, chk_idx_q;
	logic              issue_done_q, pend_q;
	logic [SITE_SLOTS-1:0] valid_q;

	// pending result
	outcome_t          outcome_q;
	logic [IDX_W-1:0]  slot_q;
	logic [CNT_W-1:0]  hits_q;

	// table
	logic                      ram_we;
	logic [ADDR_W+CNT_W-1:0]   ram_wdata, ram_rdata;
	logic [ADDR_W-1:0]         ent_addr;
	logic [CNT_W-1:0]          ent_cnt, ent_inc;
	logic [IDX_W+SLOT_W-1:0]   slot_ext;

	// output register
	logic              out_valid_q;
	logic [CNT_W-1:0]  o_sample_q, o_tick_q, o_qlock_q, o_unsafe_q, o_lost_q, o_hits_q;
	logic [DEEP_W-1:0] o_deep_q;
	outcome_t          o_outcome_q;
	logic [SLOT_W-1:0] o_slot_q;

	logic held_in;

	assign held_in  = (samples.lock_depth != '0) && !samples.lock_depth[DEPTH_W-1];
	assign ent_addr = ram_rdata[ADDR_W+CNT_W-1:CNT_W];
	assign ent_cnt  = ram_rdata[CNT_W-1:0];
	assign ent_inc  = ent_cnt + CNT_W'(1);
	assign ram_we   = cmd.fill || cmd.bump;
	assign ram_wdata = cmd.fill ? {addr_q, CNT_W'(1)} : {ent_addr, ent_inc};
	assign slot_ext = {{SLOT_W{1'b0}}, slot_q};

	hlsc_ram #(
		.WIDTH (ADDR_W + CNT_W),
		.DEPTH (SITE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (chk_idx_q),
		.wdata (ram_wdata),
		.re    (cmd.issue),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts.held_in     = held_in;
		sts.issue_done  = issue_done_q;
		sts.entry_ready = pend_q;
		sts.entry_free  = !valid_q[chk_idx_q] || (ent_cnt == '0);
		sts.entry_match = (ent_addr == addr_q);
		sts.entry_last  = (chk_idx_q == LAST_IDX);
		sts.out_free    = !out_valid_q || results.ready;
	end

	// counters, scan and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q     <= '0;
			tick_q       <= '0;
			qlock_q      <= '0;
			unsafe_q     <= '0;
			lost_q       <= '0;
			deep_q       <= '0;
			valid_q      <= '0;
			rd_idx_q     <= '0;
			chk_idx_q    <= '0;
			issue_done_q <= 1'b0;
			pend_q       <= 1'b0;
			outcome_q    <= OUT_NONE;
			slot_q       <= '0;
			hits_q       <= '0;
		end else begin
			if (cmd.take) begin
				sample_q <= sample_q + CNT_W'(1);
				if (samples.in_tick) begin
					tick_q <= tick_q + CNT_W'(1);
				end
				if (samples.in_quantum_lock) begin
					qlock_q <= qlock_q + CNT_W'(1);
				end
				if (held_in) begin
					unsafe_q <= unsafe_q + CNT_W'(1);
					if (samples.lock_depth[DEEP_W-1:0] > deep_q) begin
						deep_q <= samples.lock_depth[DEEP_W-1:0];
					end
				end
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
				pend_q       <= 1'b0;
				outcome_q    <= OUT_NONE;
				slot_q       <= '0;
				hits_q       <= '0;
			end else if (cmd.issue) begin
				chk_idx_q <= rd_idx_q;
				pend_q    <= 1'b1;
				if (rd_idx_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end else begin
				pend_q <= 1'b0;
			end

			if (cmd.fill) begin
				valid_q[chk_idx_q] <= 1'b1;
				outcome_q          <= OUT_NEW;
				slot_q             <= chk_idx_q;
				hits_q             <= CNT_W'(1);
			end
			if (cmd.bump) begin
				outcome_q <= OUT_HIT;
				slot_q    <= chk_idx_q;
				hits_q    <= ent_inc;
			end
			if (cmd.lose) begin
				lost_q    <= lost_q + CNT_W'(1);
				outcome_q <= OUT_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			addr_q <= samples.held_address;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			o_sample_q  <= sample_q;
			o_unsafe_q  <= unsafe_q;
			o_tick_q    <= tick_q;
			o_qlock_q   <= qlock_q;
			o_deep_q    <= deep_q;
			o_lost_q    <= lost_q;
			o_outcome_q <= outcome_q;
			o_slot_q    <= slot_ext[SLOT_W-1:0];
			o_hits_q    <= hits_q;
		end
	end

	assign results.valid              = out_valid_q;
	assign results.sample_total       = o_sample_q;
	assign results.unsafe_total       = o_unsafe_q;
	assign results.tick_total         = o_tick_q;
	assign results.quantum_lock_total = o_qlock_q;
	assign results.deepest            = o_deep_q;
	assign results.lost_total         = o_lost_q;
	assign results.outcome            = o_outcome_q;
	assign results.site_slot          = o_slot_q;
	assign results.site_hits          = o_hits_q;

endmodule

`default_nettype wire

@@ src/held_lock_site_census.sv @@
// ----------------------------------------------------------------------------
// held_lock_site_census
// Per-processor census of interrupt samples taken while a lock is held.
// ----------------------------------------------------------------------------
//
//   channel   | dir | handshake    | carries
//   ----------+-----+--------------+---------------------------------------------
//   samples   | in  | valid/ready  | lock_depth, held_address, in_tick,
//             |     |              | in_quantum_lock
//   results   | out | valid/ready  | running totals, deepest, outcome, site_slot,
//             |     |              | site_hits
//
// A request with no lock held goes straight to the finish state and is loaded
// into the output register once that is free. A held request walks the site
// table one slot per cycle through the registered read port of the table
// memory and stops at the first free or matching slot, or after the last slot
// when the table is full. The next request is accepted in the cycle after the
// load. One request is in flight at a time; a new one is accepted while the
// previous result still waits in the output register. A stalled results
// channel holds the sequencer before the result is loaded, never the table.
// Reset clears every counter and all slot valid flags at once, so the table
// reads as empty straight away; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module held_lock_site_census
	import hlsc_pkg::*;
#(
	parameter int unsigned SITE_SLOTS = SITE_SLOTS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hlsc_in_if.sink    samples,
	hlsc_out_if.source results
);

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: accept, scan, hand over
	hlsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// counters, site table and output register
	hlsc_dp #(
		.SITE_SLOTS (SITE_SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.samples (samples),
		.results (results)
	);

endmodule

`default_nettype wire

@@ sim/held_lock_site_census_tb.sv @@
// ----------------------------------------------------------------------------
// held_lock_site_census_tb
// Self-checking bench for the held-lock site census. A queue of sample
// requests feeds a valid/ready driver. A running census model predicts every
// result, and a monitor compares each returned result field by field. Idling
// and stalls vary by phase, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module held_lock_site_census_tb
	import hlsc_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam time         HALF_PERIOD  = 6ns;
	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned SLOTS        = SITE_SLOTS_DEF;
	// longest request is a full-table scan; allow two of them to settle
	localparam int unsigned SETTLE_CYCLES = 2 * (SITE_SLOTS_DEF + 3);
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	// one sample request as offered on the input channel
	typedef struct packed {
		logic signed [7:0] lock_depth;
		logic [31:0]       held_address;
		logic              in_tick;
		logic              in_quantum_lock;
	} sample_t;

	// one census result as returned on the output channel
	typedef struct packed {
		logic [31:0] sample_total;
		logic [31:0] unsafe_total;
		logic [31:0] tick_total;
		logic [31:0] quantum_lock_total;
		logic [6:0]  deepest;
		logic [31:0] lost_total;
		outcome_t    outcome;
		logic [3:0]  site_slot;
		logic [31:0] site_hits;
	} census_t;

	logic clk;
	logic arst_n;

	hlsc_in_if  sample_ch ();
	hlsc_out_if result_ch ();

	held_lock_site_census dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch)
	);

	// ------------------------------------------------------------------
	// Census model: its own copy of every counter and the site table.
	// Everything starts at zero, as after the one reset of the run.
	// ------------------------------------------------------------------
	logic [31:0] samples_seen  = '0;
	logic [31:0] ticks_seen    = '0;
	logic [31:0] qlocks_seen   = '0;
	logic [31:0] unsafe_seen   = '0;
	logic [6:0]  deepest_seen  = '0;
	logic [31:0] lost_seen     = '0;
	logic [31:0] site_addr  [SLOTS];
	logic [31:0] slot_tally [SLOTS];

	initial begin
		foreach (site_addr[k]) begin
			site_addr[k]  = '0;
			slot_tally[k] = '0;  // zero count marks the slot free
		end
	end

	// Advance the census by one sample and return what the block should report.
	function automatic census_t census_step(sample_t s);
		census_t r;
		logic    placed;
		r       = '0;
		placed  = 1'b0;
		r.outcome = OUT_NONE;
		samples_seen = samples_seen + 1;
		if (s.in_tick)
			ticks_seen = ticks_seen + 1;
		if (s.in_quantum_lock)
			qlocks_seen = qlocks_seen + 1;
		if (s.lock_depth > 0) begin
			unsafe_seen = unsafe_seen + 1;
			if (s.lock_depth[6:0] > deepest_seen)
				deepest_seen = s.lock_depth[6:0];
			// first free or matching slot from the bottom wins
			for (int k = 0; k < SLOTS; k++) begin
				if (!placed) begin
					if (slot_tally[k] == 0) begin
						site_addr[k]  = s.held_address;
						slot_tally[k] = 1;
						r.outcome     = OUT_NEW;
						r.site_slot   = 4'(k);
						r.site_hits   = 1;
						placed        = 1'b1;
					end else if (site_addr[k] == s.held_address) begin
						slot_tally[k] = slot_tally[k] + 1;
						r.outcome     = OUT_HIT;
						r.site_slot   = 4'(k);
						r.site_hits   = slot_tally[k];
						placed        = 1'b1;
					end
				end
			end
			if (!placed) begin
				lost_seen = lost_seen + 1;
				r.outcome = OUT_FULL;
			end
		end
		r.sample_total       = samples_seen;
		r.unsafe_total       = unsafe_seen;
		r.tick_total         = ticks_seen;
		r.quantum_lock_total = qlocks_seen;
		r.deepest            = deepest_seen;
		r.lost_total         = lost_seen;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------
	sample_t     pending_samples[$];   // requests not yet offered
	census_t     awaited_census[$];    // predicted results, oldest first
	logic [31:0] known_sites[$];       // addresses placed in the table
	int unsigned mismatches   = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_off;
	int unsigned cycle_count  = 0;

	function automatic void queue_sample(logic signed [7:0] depth, logic [31:0] addr,
			logic tick, logic qlock);
		sample_t s;
		s.lock_depth      = depth;
		s.held_address    = addr;
		s.in_tick         = tick;
		s.in_quantum_lock = qlock;
		pending_samples.push_back(s);
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%08h, got 0x%08h", field, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock and cycle limit
	// ------------------------------------------------------------------
	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver: predict each accepted request, then offer the next one
	// or idle, according to the sender idling of the current phase.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_samples
		sample_t accepted;
		sample_t next_sample;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				accepted.lock_depth      = sample_ch.lock_depth;
				accepted.held_address    = sample_ch.held_address;
				accepted.in_tick         = sample_ch.in_tick;
				accepted.in_quantum_lock = sample_ch.in_quantum_lock;
				awaited_census.push_back(census_step(accepted));
			end
			// hold an unaccepted request steady; otherwise load or drop
			if (!sample_ch.valid || sample_ch.ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_sample                = pending_samples.pop_front();
					sample_ch.lock_depth      <= next_sample.lock_depth;
					sample_ch.held_address    <= next_sample.held_address;
					sample_ch.in_tick         <= next_sample.in_tick;
					sample_ch.in_quantum_lock <= next_sample.in_quantum_lock;
					sample_ch.valid           <= 1'b1;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each accepted result with the oldest prediction,
	// then choose ready for the next cycle.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : watch_results
		census_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (awaited_census.size() == 0) begin
					$error("result returned with no request outstanding");
					mismatches++;
				end else begin
					want = awaited_census.pop_front();
					check_field("sample_total", want.sample_total, result_ch.sample_total);
					check_field("unsafe_total", want.unsafe_total, result_ch.unsafe_total);
					check_field("tick_total", want.tick_total, result_ch.tick_total);
					check_field("quantum_lock_total", want.quantum_lock_total,
						result_ch.quantum_lock_total);
					check_field("deepest", 32'(want.deepest), 32'(result_ch.deepest));
					check_field("lost_total", want.lost_total, result_ch.lost_total);
					check_field("outcome", 32'(want.outcome), 32'(result_ch.outcome));
					check_field("site_slot", 32'(want.site_slot), 32'(result_ch.site_slot));
					check_field("site_hits", want.site_hits, result_ch.site_hits);
				end
			end
			result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Queue random samples. Most held requests reuse addresses already in the
	// table so the scan stops at every depth; the rest are fresh and are lost
	// once the table is full.
	function automatic void queue_random(int unsigned count);
		logic signed [7:0] depth;
		logic [31:0]       addr;
		int unsigned       pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 60)
				depth = 8'($urandom_range(127, 1));
			else if (pick < 85)
				depth = 8'(-int'($urandom_range(128, 0)));
			else
				depth = 8'($urandom);
			if ($urandom_range(99) < 75 && known_sites.size() != 0)
				addr = known_sites[$urandom_range(known_sites.size() - 1)];
			else
				addr = $urandom;
			queue_sample(depth, addr, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endfunction

	task automatic drain_pending();
		while (pending_samples.size() != 0)
			@(posedge clk);
	endtask

	initial begin : run_census
		logic [31:0] addr;
		clk                       = 1'b0;
		arst_n                    = 1'b0;
		hold_off                  = 1'b0;
		sample_ch.valid           = 1'b0;
		sample_ch.lock_depth      = '0;
		sample_ch.held_address    = '0;
		sample_ch.in_tick         = 1'b0;
		sample_ch.in_quantum_lock = 1'b0;
		result_ch.ready           = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: no lock held at zero, most negative and minus one depth
		queue_sample(8'sd0, 32'h0000_0000, 1'b0, 1'b0);
		queue_sample(-8'sd128, 32'hFFFF_FFFF, 1'b1, 1'b1);
		queue_sample(-8'sd1, 32'h5555_5555, 1'b1, 1'b0);
		// address zero is a genuine site: new, then hit
		queue_sample(8'sd1, 32'h0000_0000, 1'b0, 1'b1);
		queue_sample(8'sd1, 32'h0000_0000, 1'b0, 1'b0);
		// deepest possible nesting, all-ones address
		queue_sample(8'sd127, 32'hFFFF_FFFF, 1'b0, 1'b1);
		queue_sample(8'sd2, 32'hFFFF_FFFF, 1'b1, 1'b1);
		known_sites.push_back(32'h0000_0000);
		known_sites.push_back(32'hFFFF_FFFF);
		// fill the remaining slots to the top of the table
		for (int k = 2; k < SLOTS; k++) begin
			addr = (k == 2) ? 32'hAAAA_AAAA : 32'h8000_0000 | (32'(k) << 4);
			queue_sample(8'(k + 1), addr, 1'(k), 1'(k >> 1));
			known_sites.push_back(addr);
		end
		// table full: a fresh site is lost, a known one still hits the top slot
		queue_sample(8'sd3, 32'h5555_5555, 1'b1, 1'b0);
		queue_sample(8'sd4, known_sites[SLOTS - 1], 1'b0, 1'b1);

		// Random phase with no idling on either side
		queue_random(160);
		drain_pending();

		// Sender mostly idle
		send_idle_pct  <= 84;
		recv_stall_pct <= 0;
		queue_random(160);
		drain_pending();

		// Receiver mostly stalled
		send_idle_pct  <= 0;
		recv_stall_pct <= 84;
		queue_random(160);
		drain_pending();

		// Both sides idling now and then
		send_idle_pct  <= 34;
		recv_stall_pct <= 34;
		queue_random(110);
		drain_pending();

		// Back-pressure: hold the receiver off while the sender keeps offering,
		// so the output register and the request in flight both fill and the
		// input stalls.
		send_idle_pct  <= 0;
		recv_stall_pct <= 0;
		queue_random(60);
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		drain_pending();

		// Wait for every request to be taken and every result returned
		while (sample_ch.valid || awaited_census.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited_census.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
src/hlsc_pkg.sv
src/hlsc_if.sv
src/hlsc_ram.sv
src/hlsc_ctrl.sv
src/hlsc_dp.sv
src/held_lock_site_census.sv
sim/held_lock_site_census_tb.sv
